### sv/max_dot_product_match_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max dot product match core
// Shared clocking and reset handling for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MAX_DOT_PRODUCT_MATCH_CORE_DEFINES_SVH
`define MAX_DOT_PRODUCT_MATCH_CORE_DEFINES_SVH

// Plain property, sampled on the core clock, off while reset is held.
`define MDPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from a condition to a consequence in the same or later cycles.
`define MDPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/mdpm_pkg.sv
// ----------------------------------------------------------------------------
// mdpm_pkg
// Types and fixed widths shared by the max dot product match core.
// ----------------------------------------------------------------------------
package mdpm_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ScoreW = 37;
  localparam int unsigned ProdW  = 32;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic [ScoreW-1:0] ScoreMax = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RUN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    logic valid;
    logic use_prod;
    logic last;
  } mac_ctrl_t;

endpackage

### sv/mdpm_in_if.sv
// ----------------------------------------------------------------------------
// mdpm_in_if
// Input channel: one vector element per item, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mdpm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic                                clicked;
  logic [mdpm_pkg::KeyW-1:0]           entry_key;
  logic signed [mdpm_pkg::ValueW-1:0]  value;
  logic                                last;

  modport source (
    output valid, mode, clicked, entry_key, value, last,
    input  ready
  );

  modport sink (
    input  valid, mode, clicked, entry_key, value, last,
    output ready
  );
endinterface

### sv/mdpm_out_if.sv
// ----------------------------------------------------------------------------
// mdpm_out_if
// Result channel: one match result per item, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mdpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [mdpm_pkg::ScoreW-1:0] score;
  logic                        has_reason;
  logic [mdpm_pkg::KeyW-1:0]   reason_key;
  logic                        ready_res;

  modport source (
    output valid, score, has_reason, reason_key, ready_res,
    input  ready
  );

  modport sink (
    input  valid, score, has_reason, reason_key, ready_res,
    output ready
  );
endinterface

### sv/mdpm_mac.sv
// ----------------------------------------------------------------------------
// mdpm_mac
// Shared multiply-accumulate unit with running maximum over the entries.
// ----------------------------------------------------------------------------
module mdpm_mac #(
  parameter int unsigned ACC_W = 38,
  parameter int unsigned IDX_W = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mdpm_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [mdpm_pkg::ValueW-1:0] vec_i,
  input  logic signed [mdpm_pkg::ValueW-1:0] val_i,
  input  logic signed [ACC_W-1:0]            acc_i,
  input  logic [mdpm_pkg::KeyW-1:0]          key_i,
  input  logic [IDX_W-1:0]                   idx_i,
  output logic                               wb_valid_o,
  output logic [IDX_W-1:0]                   wb_idx_o,
  output logic signed [ACC_W-1:0]            wb_data_o,
  output logic signed [ACC_W-1:0]            best_o,
  output logic [mdpm_pkg::KeyW-1:0]          best_key_o,
  output logic                               found_o
);

  logic signed [mdpm_pkg::ProdW-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]           acc_q;
  logic [mdpm_pkg::KeyW-1:0]         key_q;
  logic [IDX_W-1:0]                  idx_q;
  logic                              v_q, last_q;
  logic signed [ACC_W-1:0]           sum;
  logic signed [ACC_W-1:0]           best_q;
  logic [mdpm_pkg::KeyW-1:0]         best_key_q;
  logic                              found_q;

  always_comb begin
    prod_d = '0;
    if (ctrl_i.use_prod) begin
      prod_d = vec_i * val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_i;
    key_q  <= key_i;
    idx_q  <= idx_i;
    last_q <= ctrl_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= ctrl_i.valid;
    end
  end

  assign sum = acc_q + ACC_W'(prod_q);

  // On the closing element the accumulator is retired: its final value feeds the
  // maximum and a zero goes back for the next query.
  assign wb_valid_o = v_q;
  assign wb_idx_o   = idx_q;
  assign wb_data_o  = last_q ? '0 : sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q     <= '0;
      best_key_q <= '0;
      found_q    <= 1'b0;
    end else if (ctrl_i.start) begin
      best_q     <= '0;
      best_key_q <= '0;
      found_q    <= 1'b0;
    end else if (v_q && last_q && (sum > best_q)) begin
      best_q     <= sum;
      best_key_q <= key_q;
      found_q    <= 1'b1;
    end
  end

  assign best_o     = best_q;
  assign best_key_o = best_key_q;
  assign found_o    = found_q;

endmodule

### sv/max_dot_product_match_core.sv
// ----------------------------------------------------------------------------
// max_dot_product_match_core
// Stores clicked sample embeddings and finds the best inner product match
// for each streamed query vector.
// ----------------------------------------------------------------------------
//
//   channel | dir | item                               | accepted when
//   --------+-----+------------------------------------+----------------------
//   in_i    | in  | one sample or query vector element | valid & ready
//   out_o   | out | score, reason key, flags           | valid & ready
//
// A sample element is taken while idle; a short sample (last before VECTOR_LEN)
// then zero-fills the rest of its slot in the vector RAM in the FILL state.
// A query element moves to the RUN state, where the MAC unit walks the stored
// entries one per cycle through the vector, key and accumulator RAMs. With no
// entry stored it is only taken in; a query's last element adds an emit step.
// Reset clears control state only; accumulators are zeroed as entries commit
// and as each query closes, so no clearing pass is needed.
// The result sits in an output register; input keeps flowing while it stalls,
// until a further query result is ready to be loaded.
`include "max_dot_product_match_core_defines.svh"

module max_dot_product_match_core #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned VECTOR_LEN  = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mdpm_in_if.sink   in_i,
  mdpm_out_if.source out_o
);

  localparam int unsigned IdxW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ElemW  = $clog2(VECTOR_LEN + 1);
  localparam int unsigned Depth  = MAX_ENTRIES * VECTOR_LEN;
  localparam int unsigned VAddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned BaseW  = $clog2(Depth + 1);
  localparam int unsigned AccW   = 32 + $clog2(VECTOR_LEN);
  localparam int unsigned SatW   = (AccW > mdpm_pkg::ScoreW + 1) ? AccW
                                                                 : mdpm_pkg::ScoreW + 1;

  mdpm_pkg::state_e state_q, state_d;

  logic [CntW-1:0]   count_q;
  logic [BaseW-1:0]  base_q;
  logic [ElemW-1:0]  elem_q;
  logic [VAddrW-1:0] fill_addr_q;
  logic [ElemW-1:0]  fill_idx_q;
  logic signed [mdpm_pkg::ValueW-1:0] val_q;
  logic              qlast_q, use_q;
  logic [CntW-1:0]   e_q;
  logic [VAddrW-1:0] scan_addr_q;
  logic              p1_v_q;
  logic [IdxW-1:0]   p1_idx_q;

  logic                        out_valid_q;
  logic [mdpm_pkg::ScoreW-1:0] score_q;
  logic                        has_reason_q;
  logic [mdpm_pkg::KeyW-1:0]   reason_key_q;
  logic                        ready_res_q;

  logic signed [mdpm_pkg::ValueW-1:0] vec_mem [Depth];
  logic [mdpm_pkg::KeyW-1:0]          key_mem [MAX_ENTRIES];
  logic signed [AccW-1:0]             acc_mem [MAX_ENTRIES];
  logic signed [mdpm_pkg::ValueW-1:0] vec_rd_q;
  logic [mdpm_pkg::KeyW-1:0]          key_rd_q;
  logic signed [AccW-1:0]             acc_rd_q;

  logic in_acc, is_query, room, idx_ok;
  logic samp_wr, samp_last, commit, need_fill;
  logic q_run, q_emit_now, scan_done;
  logic in_ready, issue, emit_load, fill_we;
  logic [VAddrW-1:0] samp_addr;

  mdpm_pkg::mac_ctrl_t mac_ctrl;
  logic                   wb_valid;
  logic [IdxW-1:0]        wb_idx;
  logic signed [AccW-1:0] wb_data;
  logic signed [AccW-1:0] best;
  logic [mdpm_pkg::KeyW-1:0] best_key;
  logic                   found;
  logic [SatW-1:0]        best_ext;
  logic [mdpm_pkg::ScoreW-1:0] score_d;

  // --------------------------------------------------------------------------
  // Item decode
  // --------------------------------------------------------------------------
  assign in_acc    = in_i.valid && in_ready;
  assign is_query  = (in_i.mode == mdpm_pkg::MODE_QUERY);
  assign room      = (count_q < CntW'(MAX_ENTRIES));
  assign idx_ok    = (elem_q < ElemW'(VECTOR_LEN));
  assign samp_wr   = in_acc && !is_query && room && idx_ok;
  assign samp_last = in_acc && !is_query && room && in_i.last;
  assign commit    = samp_last && in_i.clicked;
  assign need_fill = samp_last && (elem_q < ElemW'(VECTOR_LEN - 1));
  assign q_run     = in_acc && is_query && (count_q != '0) && (idx_ok || in_i.last);
  assign q_emit_now = in_acc && is_query && (count_q == '0) && in_i.last;
  assign samp_addr = VAddrW'(base_q + BaseW'(elem_q));
  assign scan_done = (e_q == count_q) && !p1_v_q && !wb_valid;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdpm_pkg::ST_IDLE: begin
        if (need_fill) begin
          state_d = mdpm_pkg::ST_FILL;
        end else if (q_run) begin
          state_d = mdpm_pkg::ST_RUN;
        end else if (q_emit_now) begin
          state_d = mdpm_pkg::ST_EMIT;
        end
      end
      mdpm_pkg::ST_FILL: begin
        if (fill_idx_q == ElemW'(VECTOR_LEN - 1)) begin
          state_d = mdpm_pkg::ST_IDLE;
        end
      end
      mdpm_pkg::ST_RUN: begin
        if (scan_done) begin
          state_d = qlast_q ? mdpm_pkg::ST_EMIT : mdpm_pkg::ST_IDLE;
        end
      end
      mdpm_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = mdpm_pkg::ST_IDLE;
        end
      end
      default: state_d = mdpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    emit_load = 1'b0;
    fill_we   = 1'b0;
    unique case (state_q)
      mdpm_pkg::ST_IDLE: in_ready  = 1'b1;
      mdpm_pkg::ST_FILL: fill_we   = 1'b1;
      mdpm_pkg::ST_RUN:  issue     = (e_q != count_q);
      mdpm_pkg::ST_EMIT: emit_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdpm_pkg::ST_IDLE;
      count_q <= '0;
      base_q  <= '0;
      elem_q  <= '0;
      e_q     <= '0;
      p1_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q <= count_q + 1'b1;
        base_q  <= base_q + BaseW'(VECTOR_LEN);
      end
      if (in_acc) begin
        if (in_i.last) begin
          elem_q <= '0;
        end else if (idx_ok) begin
          elem_q <= elem_q + 1'b1;
        end
      end
      if (q_run) begin
        e_q <= '0;
      end else if (issue) begin
        e_q <= e_q + 1'b1;
      end
      p1_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (need_fill) begin
      fill_addr_q <= samp_addr + 1'b1;
      fill_idx_q  <= elem_q + 1'b1;
    end else if (fill_we) begin
      fill_addr_q <= fill_addr_q + 1'b1;
      fill_idx_q  <= fill_idx_q + 1'b1;
    end
    if (in_acc && is_query) begin
      val_q   <= in_i.value;
      qlast_q <= in_i.last;
      use_q   <= idx_ok;
    end
    // Entry e of the current element sits at e * VECTOR_LEN + index.
    if (q_run) begin
      scan_addr_q <= VAddrW'(elem_q);
    end else if (issue) begin
      scan_addr_q <= scan_addr_q + VAddrW'(VECTOR_LEN);
    end
    p1_idx_q <= e_q[IdxW-1:0];
  end

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (samp_wr) begin
      vec_mem[samp_addr] <= in_i.value;
    end else if (fill_we) begin
      vec_mem[fill_addr_q] <= '0;
    end
    vec_rd_q <= vec_mem[scan_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      key_mem[count_q[IdxW-1:0]] <= in_i.entry_key;
    end
    key_rd_q <= key_mem[e_q[IdxW-1:0]];
  end

  // A newly committed entry starts from zero so that it only sees later elements.
  always_ff @(posedge clk_i) begin
    if (wb_valid) begin
      acc_mem[wb_idx] <= wb_data;
    end else if (commit) begin
      acc_mem[count_q[IdxW-1:0]] <= '0;
    end
    acc_rd_q <= acc_mem[e_q[IdxW-1:0]];
  end

  // --------------------------------------------------------------------------
  // MAC unit
  // --------------------------------------------------------------------------
  always_comb begin
    mac_ctrl.start    = in_acc && is_query;
    mac_ctrl.valid    = p1_v_q;
    mac_ctrl.use_prod = use_q;
    mac_ctrl.last     = qlast_q;
  end

  mdpm_mac #(
    .ACC_W (AccW),
    .IDX_W (IdxW)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .vec_i      (vec_rd_q),
    .val_i      (val_q),
    .acc_i      (acc_rd_q),
    .key_i      (key_rd_q),
    .idx_i      (p1_idx_q),
    .wb_valid_o (wb_valid),
    .wb_idx_o   (wb_idx),
    .wb_data_o  (wb_data),
    .best_o     (best),
    .best_key_o (best_key),
    .found_o    (found)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  // The best value never drops below zero, so it widens as unsigned.
  assign best_ext = SatW'($unsigned(best));
  assign score_d  = (best_ext > SatW'(mdpm_pkg::ScoreMax)) ? mdpm_pkg::ScoreMax
                                                          : best_ext[mdpm_pkg::ScoreW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      score_q      <= score_d;
      has_reason_q <= found;
      reason_key_q <= best_key;
      ready_res_q  <= (count_q != '0);
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.score      = score_q;
  assign out_o.has_reason = has_reason_q;
  assign out_o.reason_key = reason_key_q;
  assign out_o.ready_res  = ready_res_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MDPM_ASSERT_IMP(a_scan_bound, state_q == mdpm_pkg::ST_RUN, e_q <= count_q,
    "entry scan ran past the stored count")
  `MDPM_ASSERT_IMP(a_count_only_on_commit,
    !(in_acc && !is_query && in_i.last && in_i.clicked), ##1 $stable(count_q),
    "stored count changed without a committed sample")
  `MDPM_ASSERT_IMP(a_result_from_emit, $rose(out_valid_q),
    $past(state_q == mdpm_pkg::ST_EMIT), "result loaded outside the emit step")
  `MDPM_ASSERT(a_no_wb_when_idle, !(wb_valid && (state_q != mdpm_pkg::ST_RUN)),
    "accumulator write-back outside a query scan")

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample and query elements into the max dot product match core,
// predicts each query result with an independent inner product tracker, and
// compares every result field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MaxEntries  = 64;
  localparam int unsigned VecLen      = 64;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned MinQueries  = 40;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned TailCycles  = 150;

  typedef enum int unsigned {
    VAL_RANDOM,
    VAL_POOL,
    VAL_EXTREME
  } value_kind_e;

  typedef struct packed {
    logic                               mode;
    logic                               clicked;
    logic [mdpm_pkg::KeyW-1:0]          entry_key;
    logic signed [mdpm_pkg::ValueW-1:0] value;
    logic                               last;
    logic                               hold;
  } elem_t;

  typedef struct packed {
    logic [mdpm_pkg::ScoreW-1:0] score;
    logic                        has_reason;
    logic [mdpm_pkg::KeyW-1:0]   reason_key;
    logic                        ready_res;
  } match_t;

  logic clk_i;
  logic rst_ni;

  mdpm_in_if  in_bus ();
  mdpm_out_if out_bus ();

  max_dot_product_match_core #(
    .MAX_ENTRIES(MaxEntries),
    .VECTOR_LEN (VecLen)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  elem_t  elem_queue[$];
  match_t pending_matches[$];
  int unsigned n_total;
  int unsigned n_accepted;
  int unsigned n_errors;

  // Inner product tracker: what the core holds and has summed so far.
  logic signed [mdpm_pkg::ValueW-1:0] emb_mem [MaxEntries][VecLen];
  logic [mdpm_pkg::KeyW-1:0]          key_mem [MaxEntries];
  longint                             dot_acc [MaxEntries];
  int unsigned                        n_stored;
  int unsigned                        elem_pos;

  // Stimulus side bookkeeping, so that no committed slot has unwritten elements.
  logic [VecLen-1:0] gen_mask [MaxEntries];
  int unsigned       gen_count;
  int unsigned       gen_pos;
  int unsigned       n_effective;
  int unsigned       n_queries;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  function automatic int unsigned draw_gap(inout int unsigned run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic update_inner_products(input elem_t it);
    match_t      res;
    longint      best;
    logic        found;
    logic [mdpm_pkg::KeyW-1:0] best_key;
    int unsigned e;
    int unsigned i;
    if (it.mode == mdpm_pkg::MODE_SAMPLE) begin
      if (n_stored < MaxEntries) begin
        if (elem_pos < VecLen) emb_mem[n_stored][elem_pos] = it.value;
        if (it.last) begin
          for (i = elem_pos + 1; i < VecLen; i++) emb_mem[n_stored][i] = '0;
          if (it.clicked) begin
            key_mem[n_stored] = it.entry_key;
            n_stored++;
          end
        end
      end
      elem_pos = it.last ? 0 : ((elem_pos < VecLen) ? elem_pos + 1 : elem_pos);
    end else begin
      if (elem_pos < VecLen) begin
        for (e = 0; e < n_stored; e++) begin
          dot_acc[e] += longint'(emb_mem[e][elem_pos]) * longint'($signed(it.value));
        end
      end
      if (!it.last) begin
        elem_pos = (elem_pos < VecLen) ? elem_pos + 1 : elem_pos;
      end else begin
        best     = 0;
        found    = 1'b0;
        best_key = '0;
        // Strictly greater keeps the earliest entry on a tie.
        for (e = 0; e < n_stored; e++) begin
          if (dot_acc[e] > best) begin
            best     = dot_acc[e];
            best_key = key_mem[e];
            found    = 1'b1;
          end
        end
        res.score      = (best > longint'(mdpm_pkg::ScoreMax)) ? mdpm_pkg::ScoreMax
                                                               : best[mdpm_pkg::ScoreW-1:0];
        res.has_reason = found;
        res.reason_key = best_key;
        res.ready_res  = (n_stored > 0);
        pending_matches.push_back(res);
        for (e = 0; e < MaxEntries; e++) dot_acc[e] = 0;
        elem_pos = 0;
      end
    end
  endtask

  task automatic add_elem(input logic mode, input logic clicked,
                          input logic [mdpm_pkg::KeyW-1:0] key,
                          input logic signed [mdpm_pkg::ValueW-1:0] value, input logic last,
                          input logic hold);
    elem_t       it;
    int unsigned i;
    n_effective++;
    if (mode == mdpm_pkg::MODE_SAMPLE) begin
      if (gen_count < MaxEntries) begin
        if (gen_pos < VecLen) gen_mask[gen_count][gen_pos] = 1'b1;
        if (last) begin
          for (i = gen_pos + 1; i < VecLen; i++) gen_mask[gen_count][i] = 1'b1;
          // A sample that began mid-vector would leave holes; keep it uncommitted.
          if (clicked && !(&gen_mask[gen_count])) clicked = 1'b0;
          if (clicked) gen_count++;
        end
      end
      gen_pos = last ? 0 : ((gen_pos < VecLen) ? gen_pos + 1 : gen_pos);
    end else begin
      if (last) n_queries++;
      gen_pos = last ? 0 : ((gen_pos < VecLen) ? gen_pos + 1 : gen_pos);
    end
    it.mode      = mode;
    it.clicked   = clicked;
    it.entry_key = key;
    it.value     = value;
    it.last      = last;
    it.hold      = hold;
    elem_queue.push_back(it);
  endtask

  function automatic logic signed [mdpm_pkg::ValueW-1:0] pick_value(input value_kind_e kind);
    logic signed [mdpm_pkg::ValueW-1:0] v;
    case (kind)
      VAL_POOL: begin
        case ($urandom_range(0, 6))
          0:       v = 16'sh8000;
          1:       v = -16'sd16384;
          2:       v = -16'sd1;
          3:       v = 16'sd0;
          4:       v = 16'sd1;
          5:       v = 16'sd16384;
          default: v = 16'sh7FFF;
        endcase
      end
      VAL_EXTREME: v = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
      default:     v = mdpm_pkg::ValueW'($urandom);
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_len(input logic for_sample);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (for_sample) begin
      if (r < 90) return $urandom_range(1, 4);
      if (r < 96) return VecLen;
      return $urandom_range(VecLen + 1, VecLen + 6);
    end
    if (r < 80) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 24);
    if (r < 95) return VecLen;
    return $urandom_range(VecLen + 1, VecLen + 6);
  endfunction

  task automatic add_vector(input logic mode, input int unsigned len, input logic clicked,
                            input value_kind_e kind, input logic hold);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      add_elem(mode, clicked, mdpm_pkg::KeyW'($urandom), pick_value(kind), (k == len - 1),
               hold && (k == 0));
    end
  endtask

  task automatic build_stimulus();
    int unsigned r;
    int unsigned sel;
    int unsigned k;
    int unsigned burst;
    logic        first;
    logic        hold;
    logic        topped_up;
    value_kind_e kind;

    // Query against an empty store.
    add_elem(mdpm_pkg::MODE_QUERY, 1'b0, '0, 16'sh8000, 1'b1, 1'b0);
    // Unclicked sample, then three short clicked ones, two of them equal.
    add_elem(mdpm_pkg::MODE_SAMPLE, 1'b1, mdpm_pkg::KeyW'($urandom), 16'sh7FFF, 1'b0, 1'b0);
    add_elem(mdpm_pkg::MODE_SAMPLE, 1'b0, 32'hFFFF_FFFF, 16'sh8000, 1'b1, 1'b0);
    add_elem(mdpm_pkg::MODE_SAMPLE, 1'b1, 32'hFFFF_FFFF, 16'sh8000, 1'b1, 1'b0);
    add_elem(mdpm_pkg::MODE_SAMPLE, 1'b0, '0, 16'sh8000, 1'b0, 1'b0);
    add_elem(mdpm_pkg::MODE_SAMPLE, 1'b1, '0, 16'sh7FFF, 1'b1, 1'b0);
    add_elem(mdpm_pkg::MODE_SAMPLE, 1'b1, 32'h5A5A_5A5A, 16'sh8000, 1'b1, 1'b0);
    // Tie on the best product, then all negative, then all zero.
    add_elem(mdpm_pkg::MODE_QUERY, 1'b0, '0, 16'sh8000, 1'b1, 1'b0);
    add_elem(mdpm_pkg::MODE_QUERY, 1'b0, '0, 16'sh7FFF, 1'b0, 1'b0);
    add_elem(mdpm_pkg::MODE_QUERY, 1'b0, '0, 16'sh7FFF, 1'b1, 1'b0);
    add_elem(mdpm_pkg::MODE_QUERY, 1'b0, '0, 16'sd0, 1'b1, 1'b0);
    // A sample interleaved into an open query, committing an entry mid-query.
    add_elem(mdpm_pkg::MODE_QUERY, 1'b0, '0, 16'sd16384, 1'b0, 1'b0);
    add_elem(mdpm_pkg::MODE_SAMPLE, 1'b0, '0, 16'sd1, 1'b1, 1'b0);
    add_elem(mdpm_pkg::MODE_SAMPLE, 1'b1, 32'h0000_1234, 16'sh7FFF, 1'b1, 1'b0);
    add_elem(mdpm_pkg::MODE_QUERY, 1'b0, '0, 16'sh7FFF, 1'b1, 1'b0);
    add_elem(mdpm_pkg::MODE_QUERY, 1'b0, '0, -16'sd1, 1'b0, 1'b0);
    add_elem(mdpm_pkg::MODE_QUERY, 1'b0, '0, -16'sd1, 1'b1, 1'b0);
    add_elem(mdpm_pkg::MODE_SAMPLE, 1'b1, 32'hA5A5_0F0F, 16'sh5555, 1'b1, 1'b0);
    add_elem(mdpm_pkg::MODE_QUERY, 1'b0, 32'h5A5A_F0F0, 16'shAAAA, 1'b1, 1'b0);

    first     = 1'b1;
    topped_up = 1'b0;
    while (n_effective < RandomItems || n_queries < MinQueries) begin
      hold  = first || ($urandom_range(0, 24) == 0);
      first = 1'b0;
      r     = $urandom_range(0, 99);
      if (r < 50) begin
        kind = VAL_RANDOM;
      end else if (r < 85) begin
        kind = VAL_POOL;
      end else begin
        kind = VAL_EXTREME;
      end
      if (!topped_up && n_effective > RandomItems * 2 / 3) begin
        // Fill the store so that the rest of the run sees dropped samples.
        topped_up = 1'b1;
        while (gen_count < MaxEntries) begin
          add_vector(mdpm_pkg::MODE_SAMPLE, $urandom_range(1, 3), 1'b1, kind, hold);
          hold = 1'b0;
        end
      end
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        add_vector(mdpm_pkg::MODE_SAMPLE, pick_len(1'b1), ($urandom_range(0, 9) < 8), kind,
                   hold);
      end else if (sel < 8) begin
        add_vector(mdpm_pkg::MODE_QUERY, pick_len(1'b0), 1'b0, kind, hold);
      end else if (sel == 8) begin
        burst = $urandom_range(3, 8);
        for (k = 0; k < burst; k++) begin
          add_elem(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                   mdpm_pkg::KeyW'($urandom), pick_value(kind), ($urandom_range(0, 3) == 0),
                   hold && (k == 0));
        end
      end else begin
        burst = $urandom_range(1, 3);
        for (k = 0; k < burst; k++) begin
          add_elem(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                   mdpm_pkg::KeyW'($urandom), mdpm_pkg::ValueW'($urandom),
                   logic'($urandom_range(0, 1)), hold && (k == 0));
        end
      end
    end
  endtask

  // Driver: presents queued elements and feeds each accepted one to the tracker.
  elem_t       cur_elem;
  int unsigned send_wait;
  int unsigned send_run;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid     <= 1'b0;
      in_bus.mode      <= mdpm_pkg::MODE_SAMPLE;
      in_bus.clicked   <= 1'b0;
      in_bus.entry_key <= '0;
      in_bus.value     <= '0;
      in_bus.last      <= 1'b0;
      send_wait = 0;
      send_run  = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        update_inner_products(cur_elem);
        n_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_wait > 0) begin
          in_bus.valid <= 1'b0;
          send_wait--;
        end else if (elem_queue.size() > 0 &&
                     (!elem_queue[0].hold || pending_matches.size() == 0)) begin
          cur_elem = elem_queue.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.mode      <= cur_elem.mode;
          in_bus.clicked   <= cur_elem.clicked;
          in_bus.entry_key <= cur_elem.entry_key;
          in_bus.value     <= cur_elem.value;
          in_bus.last      <= cur_elem.last;
          send_wait = draw_gap(send_run);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest predicted match.
  match_t      want;
  int unsigned recv_wait;
  int unsigned recv_run;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      recv_wait = 0;
      recv_run  = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_matches.size() == 0) begin
          report_mismatch($sformatf("result with score %0h while no query is open",
                                    out_bus.score));
        end else begin
          want = pending_matches.pop_front();
          if (out_bus.score !== want.score)
            report_mismatch($sformatf("score %0h, expected %0h", out_bus.score, want.score));
          if (out_bus.has_reason !== want.has_reason)
            report_mismatch($sformatf("has_reason %0b, expected %0b",
                                      out_bus.has_reason, want.has_reason));
          if (out_bus.reason_key !== want.reason_key)
            report_mismatch($sformatf("reason_key %0h, expected %0h",
                                      out_bus.reason_key, want.reason_key));
          if (out_bus.ready_res !== want.ready_res)
            report_mismatch($sformatf("ready_res %0b, expected %0b",
                                      out_bus.ready_res, want.ready_res));
        end
        recv_wait = draw_gap(recv_run);
      end
      if (recv_wait > 0) begin
        out_bus.ready <= 1'b0;
        recv_wait--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : main
    int unsigned e;
    rst_ni      = 1'b0;
    n_accepted  = 0;
    n_errors    = 0;
    n_stored    = 0;
    elem_pos    = 0;
    gen_count   = 0;
    gen_pos     = 0;
    n_effective = 0;
    n_queries   = 0;
    for (e = 0; e < MaxEntries; e++) begin
      dot_acc[e]  = 0;
      gen_mask[e] = '0;
    end
    build_stimulus();
    n_total = elem_queue.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total || pending_matches.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
